// ===== sv/m68kie_pkg.sv =====
// Shared types and constants for the 68000 interrupt and exception entry unit.
`timescale 1ns / 1ps
`default_nettype none

package m68kie_pkg;

    // Action codes of an input item
    localparam logic [2:0] ACT_RAISE_EXT   = 3'd0;
    localparam logic [2:0] ACT_RAISE_INPUT = 3'd1;
    localparam logic [2:0] ACT_RAISE_LEVEL = 3'd2;
    localparam logic [2:0] ACT_SAFEPOINT   = 3'd3;
    localparam logic [2:0] ACT_EXCEPTION   = 3'd4;
    localparam logic [2:0] ACT_WRITE_SR    = 3'd5;
    localparam logic [2:0] ACT_STOP        = 3'd6;

    localparam logic [3:0] SHORT_WRITES = 4'd3;
    localparam logic [3:0] LONG_WRITES  = 4'd13;
    localparam logic [15:0] FORMAT_LONG = 16'hF000;

    typedef enum logic [1:0] {
        FRAME_NONE,
        FRAME_SHORT,
        FRAME_LONG
    } frame_kind_t;

    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_OPCODE,
        SEL_FAULT,
        SEL_FORMAT,
        SEL_VOFF,
        SEL_PC,
        SEL_SR
    } data_sel_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  irq_level;
        logic [1:0]  onchip_input;
        logic [7:0]  vector_number;
        logic [15:0] current_sr;
        logic [15:0] new_sr_value;
        logic [31:0] stacked_pc;
        logic [31:0] active_stack_pointer;
        logic [31:0] fault_address;
        logic [15:0] fault_opcode;
        logic        delivery_enable;
    } item_t;

    typedef struct packed {
        logic        last;
        logic        is_write;
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic        write_is_long;
        logic        exception_taken;
        logic [7:0]  vector_out;
        logic [15:0] sr_out;
        logic [31:0] stack_pointer_out;
        logic        halted_out;
        logic [2:0]  pending_level_out;
        logic [7:0]  exception_cycles;
    } result_t;

    // Work handed from the front to the back sequencer
    typedef struct packed {
        frame_kind_t kind;
        logic [7:0]  vector;
        logic [31:0] pc;
        logic [15:0] old_sr;
        logic [15:0] opcode;
        logic [31:0] fault;
        logic [31:0] sp_start;
        logic        taken;
        logic [15:0] sr_out;
        logic [31:0] sp_out;
        logic        halted;
        logic [2:0]  pending;
        logic [7:0]  cycles;
    } job_t;

endpackage

`default_nettype wire

// ===== sv/m68k_interrupt_exception_entry_unit.sv =====
// Top level of the 68000 interrupt and exception entry unit.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      item_t   one action per beat
//  m_        out        m_valid / m_ready      result_t write or status beats
//  cfg_      in         cfg_valid / cfg_ready  8-bit on-chip level register
//
// Each item yields one status beat, preceded by 3 stack writes for a short
// frame or 13 for a long fault frame. The frame sequencer emits one beat per
// cycle from a registered output while a job is queued and m_ready is high.
// The front end accepts a new item every cycle while the job queue has room.
// Reset (aresetn low at a clock edge) clears the pending masks, stack shadows,
// STOP latch, level register, queue and output valid.
// m_ready low holds the output beat; the queue absorbs QUEUE_DEPTH items
// before s_ready drops. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module m68k_interrupt_exception_entry_unit import m68kie_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire item_t      s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output result_t         m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic q_ready;
    logic q_push;
    job_t q_data;
    logic q_pop;
    logic head_valid;
    job_t head_data;

    m68kie_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    m68kie_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_ready),
        .push_data  (q_data),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    m68kie_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ===== sv/m68kie_front.sv =====
// Front end: accepts items, keeps pending masks, stack shadows and STOP latch.
`timescale 1ns / 1ps
`default_nettype none

module m68kie_front import m68kie_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire item_t      s_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    input  wire logic       q_ready,
    output logic            q_push,
    output job_t            q_data
);

    localparam logic [1:0] SRC_ONE         = 2'd1;
    localparam logic [1:0] SRC_TWO         = 2'd2;
    localparam logic [7:0] VEC_BUS_ERROR   = 8'd2;
    localparam logic [7:0] VEC_ADDR_ERROR  = 8'd3;
    localparam logic [7:0] AUTOVEC_EXT     = 8'd24;
    localparam logic [7:0] AUTOVEC_ONCHIP  = 8'd56;
    localparam logic [7:0] CYCLES_IRQ      = 8'd65;
    localparam logic [7:0] CYCLES_FAULT    = 8'd158;
    localparam logic [2:0] LEVEL_NMI       = 3'd7;
    localparam int         SR_S_BIT        = 13;
    localparam logic [31:0] SHORT_BYTES    = 32'd8;
    localparam logic [31:0] LONG_BYTES     = 32'd34;

    logic [7:0]  ext_reg, ext_next;
    logic [7:0]  onc_reg, onc_next;
    logic [31:0] usp_reg, usp_next;
    logic [31:0] ssp_reg, ssp_next;
    logic        stop_reg, stop_next;
    logic [7:0]  lvl_sel_reg;

    logic        accept;
    logic [2:0]  src_level;
    logic [2:0]  cur_top;
    logic        cur_onc;
    logic        take_irq;
    logic        frame_go;
    logic        frame_long;
    logic [7:0]  vec;
    logic [31:0] sp_start;

    function automatic logic [2:0] top_level(input logic [7:0] mask);
        logic [2:0] lv;
        lv = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (mask[i]) begin
                lv = 3'(i);
            end
        end
        return lv;
    endfunction

    assign s_ready   = q_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept;

    assign cur_top  = top_level(ext_reg | onc_reg);
    assign cur_onc  = onc_reg[cur_top];
    assign take_irq = (cur_top != 3'd0) &&
                      ((cur_top == LEVEL_NMI) || (cur_top > s_data.current_sr[10:8])) &&
                      s_data.delivery_enable;

    always_comb begin
        ext_next   = ext_reg;
        onc_next   = onc_reg;
        usp_next   = usp_reg;
        ssp_next   = ssp_reg;
        stop_next  = stop_reg;
        frame_go   = 1'b0;
        frame_long = 1'b0;
        vec        = 8'd0;
        src_level  = 3'd0;
        sp_start   = s_data.active_stack_pointer;

        q_data.kind     = FRAME_NONE;
        q_data.vector   = 8'd0;
        q_data.pc       = s_data.stacked_pc;
        q_data.old_sr   = s_data.current_sr;
        q_data.opcode   = s_data.fault_opcode;
        q_data.fault    = s_data.fault_address;
        q_data.sp_start = s_data.active_stack_pointer;
        q_data.taken    = 1'b0;
        q_data.sr_out   = s_data.current_sr;
        q_data.sp_out   = s_data.active_stack_pointer;
        q_data.halted   = 1'b0;
        q_data.pending  = 3'd0;
        q_data.cycles   = 8'd0;

        case (s_data.action)
            ACT_RAISE_EXT: begin
                ext_next = ext_reg | (8'd1 << s_data.irq_level);
            end
            ACT_RAISE_INPUT: begin
                if (s_data.onchip_input == SRC_ONE) begin
                    src_level = lvl_sel_reg[6:4];
                end else if (s_data.onchip_input == SRC_TWO) begin
                    src_level = lvl_sel_reg[2:0];
                end
                if (src_level != 3'd0) begin
                    onc_next = onc_reg | (8'd1 << src_level);
                end
            end
            ACT_RAISE_LEVEL: begin
                if (s_data.irq_level != 3'd0) begin
                    onc_next = onc_reg | (8'd1 << s_data.irq_level);
                end
            end
            ACT_SAFEPOINT: begin
                if (take_irq) begin
                    // on-chip source wins a tie at the same level
                    if (cur_onc) begin
                        onc_next[cur_top] = 1'b0;
                        vec = AUTOVEC_ONCHIP + {5'd0, cur_top};
                    end else begin
                        ext_next[cur_top] = 1'b0;
                        vec = AUTOVEC_EXT + {5'd0, cur_top};
                    end
                    stop_next     = 1'b0;
                    frame_go      = 1'b1;
                    q_data.cycles = CYCLES_IRQ;
                end
            end
            ACT_EXCEPTION: begin
                vec        = s_data.vector_number;
                frame_go   = 1'b1;
                frame_long = (vec == VEC_BUS_ERROR) || (vec == VEC_ADDR_ERROR);
                q_data.cycles = frame_long ? CYCLES_FAULT : 8'd0;
            end
            ACT_WRITE_SR, ACT_STOP: begin
                // swap A7 with the shadow when S flips
                if (s_data.current_sr[SR_S_BIT] != s_data.new_sr_value[SR_S_BIT]) begin
                    if (s_data.current_sr[SR_S_BIT]) begin
                        ssp_next = s_data.active_stack_pointer;
                        sp_start = usp_reg;
                    end else begin
                        usp_next = s_data.active_stack_pointer;
                        sp_start = ssp_reg;
                    end
                end
                q_data.sr_out = s_data.new_sr_value;
                q_data.sp_out = sp_start;
                if (s_data.action == ACT_STOP) begin
                    stop_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (frame_go) begin
            // enter supervisor: swap stacks if coming from user mode
            if (!s_data.current_sr[SR_S_BIT]) begin
                usp_next = s_data.active_stack_pointer;
                sp_start = ssp_reg;
            end
            q_data.kind             = frame_long ? FRAME_LONG : FRAME_SHORT;
            q_data.vector           = vec;
            q_data.sp_start         = sp_start;
            q_data.sp_out           = sp_start - (frame_long ? LONG_BYTES : SHORT_BYTES);
            q_data.taken            = 1'b1;
            q_data.sr_out           = s_data.current_sr;
            q_data.sr_out[SR_S_BIT] = 1'b1;
        end

        q_data.halted  = stop_next;
        q_data.pending = top_level(ext_next | onc_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg     <= 8'd0;
            onc_reg     <= 8'd0;
            usp_reg     <= 32'd0;
            ssp_reg     <= 32'd0;
            stop_reg    <= 1'b0;
            lvl_sel_reg <= 8'd0;
        end else begin
            if (accept) begin
                ext_reg  <= ext_next;
                onc_reg  <= onc_next;
                usp_reg  <= usp_next;
                ssp_reg  <= ssp_next;
                stop_reg <= stop_next;
            end
            if (cfg_valid && cfg_ready) begin
                lvl_sel_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/m68kie_queue.sv =====
// Small job queue between the front end and the frame sequencer.
`timescale 1ns / 1ps
`default_nettype none

module m68kie_queue import m68kie_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    output logic      push_ready,
    input  wire job_t push_data,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/m68kie_back.sv =====
// Frame sequencer: emits the stack write beats of a job, then its status beat.
`timescale 1ns / 1ps
`default_nettype none

module m68kie_back import m68kie_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic head_valid,
    input  wire job_t head_data,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output result_t   m_data
);

    typedef struct packed {
        data_sel_t sel;
        logic      is_long;
    } step_t;

    logic [3:0]  step_reg;
    logic [31:0] addr_reg;
    logic        m_valid_reg;
    result_t     m_data_reg;

    logic [3:0]  n_writes;
    logic        load;
    logic        is_status;
    step_t       fs;
    logic [31:0] base;
    logic [31:0] waddr;
    logic [31:0] wdata;
    result_t     beat;

    function automatic step_t frame_step(input logic long_frame, input logic [3:0] idx);
        step_t s;
        s = '{sel: SEL_SR, is_long: 1'b0};
        if (long_frame) begin
            case (idx)
                4'd0:    s = '{sel: SEL_ZERO,   is_long: 1'b0};
                4'd1:    s = '{sel: SEL_OPCODE, is_long: 1'b0};
                4'd2:    s = '{sel: SEL_OPCODE, is_long: 1'b0};
                4'd3:    s = '{sel: SEL_ZERO,   is_long: 1'b1};
                4'd4:    s = '{sel: SEL_FAULT,  is_long: 1'b1};
                4'd5:    s = '{sel: SEL_ZERO,   is_long: 1'b1};
                4'd6:    s = '{sel: SEL_ZERO,   is_long: 1'b0};
                4'd7:    s = '{sel: SEL_ZERO,   is_long: 1'b0};
                4'd8:    s = '{sel: SEL_ZERO,   is_long: 1'b0};
                4'd9:    s = '{sel: SEL_ZERO,   is_long: 1'b0};
                4'd10:   s = '{sel: SEL_FORMAT, is_long: 1'b0};
                4'd11:   s = '{sel: SEL_PC,     is_long: 1'b1};
                default: s = '{sel: SEL_SR,     is_long: 1'b0};
            endcase
        end else begin
            case (idx)
                4'd0:    s = '{sel: SEL_VOFF, is_long: 1'b0};
                4'd1:    s = '{sel: SEL_PC,   is_long: 1'b1};
                default: s = '{sel: SEL_SR,   is_long: 1'b0};
            endcase
        end
        return s;
    endfunction

    always_comb begin
        case (head_data.kind)
            FRAME_LONG:  n_writes = LONG_WRITES;
            FRAME_SHORT: n_writes = SHORT_WRITES;
            default:     n_writes = 4'd0;
        endcase
    end

    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign is_status = (step_reg == n_writes);
    assign pop       = load && is_status;
    assign fs        = frame_step(head_data.kind == FRAME_LONG, step_reg);
    assign base      = (step_reg == 4'd0) ? head_data.sp_start : addr_reg;
    // predecrement the stack pointer by the beat's size
    assign waddr     = base - (fs.is_long ? 32'd4 : 32'd2);

    always_comb begin
        case (fs.sel)
            SEL_ZERO:   wdata = 32'd0;
            SEL_OPCODE: wdata = {16'd0, head_data.opcode};
            SEL_FAULT:  wdata = head_data.fault;
            SEL_FORMAT: wdata = {16'd0, FORMAT_LONG | {6'd0, head_data.vector, 2'b00}};
            SEL_VOFF:   wdata = {22'd0, head_data.vector, 2'b00};
            SEL_PC:     wdata = head_data.pc;
            SEL_SR:     wdata = {16'd0, head_data.old_sr};
            default:    wdata = 32'd0;
        endcase
    end

    always_comb begin
        beat = '0;
        if (is_status) begin
            beat.last              = 1'b1;
            beat.exception_taken   = head_data.taken;
            beat.vector_out        = head_data.vector;
            beat.sr_out            = head_data.sr_out;
            beat.stack_pointer_out = head_data.sp_out;
            beat.halted_out        = head_data.halted;
            beat.pending_level_out = head_data.pending;
            beat.exception_cycles  = head_data.cycles;
        end else begin
            beat.is_write      = 1'b1;
            beat.write_address = waddr;
            beat.write_data    = wdata;
            beat.write_is_long = fs.is_long;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= beat;
            if (!is_status) begin
                addr_reg <= waddr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= 4'd0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                step_reg    <= is_status ? 4'd0 : step_reg + 4'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= LONG_WRITES)
        else $error("frame step past the long frame");

    a_short_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head_data.kind == FRAME_SHORT) |-> step_reg <= SHORT_WRITES)
        else $error("short frame step out of range");

    a_job_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != 4'd0) |-> head_valid)
        else $error("frame in progress lost its job");

endmodule

`default_nettype wire

// ===== tb/sv/m68kie_frame_checker.sv =====
// Checker for the 68000 exception entry unit: predicts every beat and compares.
`timescale 1ns / 1ps

module m68kie_frame_checker import m68kie_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire item_t      s_data,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire result_t    m_data,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [7:0] cfg_data,
    output int              fail_count,
    output int              beats_outstanding
);

    localparam int         SR_S           = 13;
    localparam logic [7:0] VEC_BUS_ERROR  = 8'd2;
    localparam logic [7:0] VEC_ADDR_ERROR = 8'd3;
    localparam logic [7:0] AUTOVEC_EXT    = 8'd24;
    localparam logic [7:0] AUTOVEC_ONCHIP = 8'd56;
    localparam logic [7:0] CYCLES_IRQ     = 8'd65;
    localparam logic [7:0] CYCLES_FAULT   = 8'd158;
    localparam logic [2:0] NMI_LEVEL      = 3'd7;

    logic [7:0]  ext_pending;
    logic [7:0]  onchip_pending;
    logic [31:0] usp_shadow;
    logic [31:0] ssp_shadow;
    logic        halted;
    logic [7:0]  level_select;
    logic [31:0] work_sp;
    logic [15:0] work_sr;
    result_t     beats_due[$];
    int          mismatches;

    function automatic logic [2:0] top_pending();
        logic [7:0] mask;
        logic [2:0] lv;
        mask = ext_pending | onchip_pending;
        lv = 3'd0;
        // bit 0 is never a pending level
        for (int l = 1; l <= 7; l++) if (mask[l]) lv = l[2:0];
        return lv;
    endfunction

    task automatic swap_stack(input logic [15:0] old_sr, input logic [15:0] new_sr);
        if (old_sr[SR_S] != new_sr[SR_S]) begin
            if (old_sr[SR_S]) begin
                ssp_shadow = work_sp;
                work_sp = usp_shadow;
            end else begin
                usp_shadow = work_sp;
                work_sp = ssp_shadow;
            end
        end
    endtask

    task automatic stack_push(input logic [31:0] data, input logic is_long);
        result_t r;
        work_sp = work_sp - (is_long ? 32'd4 : 32'd2);
        r = '0;
        r.is_write = 1'b1;
        r.write_address = work_sp;
        r.write_data = is_long ? data : {16'd0, data[15:0]};
        r.write_is_long = is_long;
        beats_due.push_back(r);
    endtask

    task automatic push_frame(input logic [7:0] vec, input item_t it);
        logic [15:0] old_sr;
        logic [15:0] voff;
        old_sr = work_sr;
        voff = {6'd0, vec, 2'b00};
        swap_stack(old_sr, old_sr | (16'd1 << SR_S));
        work_sr = old_sr | (16'd1 << SR_S);
        if (vec == VEC_BUS_ERROR || vec == VEC_ADDR_ERROR) begin
            stack_push(32'd0, 1'b0);
            stack_push({16'd0, it.fault_opcode}, 1'b0);
            stack_push({16'd0, it.fault_opcode}, 1'b0);
            stack_push(32'd0, 1'b1);
            stack_push(it.fault_address, 1'b1);
            stack_push(32'd0, 1'b1);
            for (int n = 0; n < 4; n++) stack_push(32'd0, 1'b0);
            stack_push({16'd0, FORMAT_LONG | voff}, 1'b0);
        end else begin
            stack_push({16'd0, voff}, 1'b0);
        end
        stack_push(it.stacked_pc, 1'b1);
        stack_push({16'd0, old_sr}, 1'b0);
    endtask

    task automatic predict_entry(input item_t it);
        result_t     st;
        logic [2:0]  lv;
        logic [2:0]  src_level;
        logic        from_onchip;
        logic        took;
        logic [7:0]  vec;
        logic [7:0]  cyc;
        work_sp = it.active_stack_pointer;
        work_sr = it.current_sr;
        took = 1'b0;
        vec = 8'd0;
        cyc = 8'd0;
        case (it.action)
            ACT_RAISE_EXT: ext_pending[it.irq_level] = 1'b1;
            ACT_RAISE_INPUT: begin
                src_level = (it.onchip_input == 2'd1) ? level_select[6:4] :
                            (it.onchip_input == 2'd2) ? level_select[2:0] : 3'd0;
                if (src_level != 3'd0) onchip_pending[src_level] = 1'b1;
            end
            ACT_RAISE_LEVEL: begin
                if (it.irq_level != 3'd0) onchip_pending[it.irq_level] = 1'b1;
            end
            ACT_SAFEPOINT: begin
                lv = top_pending();
                if (lv != 3'd0 && (lv == NMI_LEVEL || lv > it.current_sr[10:8]) &&
                        it.delivery_enable) begin
                    // on-chip source wins when both masks hold the level
                    from_onchip = onchip_pending[lv];
                    if (from_onchip) onchip_pending[lv] = 1'b0;
                    else ext_pending[lv] = 1'b0;
                    halted = 1'b0;
                    vec = (from_onchip ? AUTOVEC_ONCHIP : AUTOVEC_EXT) + {5'd0, lv};
                    push_frame(vec, it);
                    took = 1'b1;
                    cyc = CYCLES_IRQ;
                end
            end
            ACT_EXCEPTION: begin
                vec = it.vector_number;
                push_frame(vec, it);
                took = 1'b1;
                cyc = (vec == VEC_BUS_ERROR || vec == VEC_ADDR_ERROR) ? CYCLES_FAULT : 8'd0;
            end
            ACT_WRITE_SR, ACT_STOP: begin
                swap_stack(work_sr, it.new_sr_value);
                work_sr = it.new_sr_value;
                if (it.action == ACT_STOP) halted = 1'b1;
            end
            default: ;
        endcase
        st = '0;
        st.last = 1'b1;
        st.exception_taken = took;
        st.vector_out = vec;
        st.sr_out = work_sr;
        st.stack_pointer_out = work_sp;
        st.halted_out = halted;
        st.pending_level_out = top_pending();
        st.exception_cycles = cyc;
        beats_due.push_back(st);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_beat(input result_t want, input result_t got);
        check_field("last", 32'(want.last), 32'(got.last));
        check_field("is_write", 32'(want.is_write), 32'(got.is_write));
        check_field("write_address", want.write_address, got.write_address);
        check_field("write_data", want.write_data, got.write_data);
        check_field("write_is_long", 32'(want.write_is_long), 32'(got.write_is_long));
        check_field("exception_taken", 32'(want.exception_taken),
                    32'(got.exception_taken));
        check_field("vector_out", 32'(want.vector_out), 32'(got.vector_out));
        check_field("sr_out", 32'(want.sr_out), 32'(got.sr_out));
        check_field("stack_pointer_out", want.stack_pointer_out, got.stack_pointer_out);
        check_field("halted_out", 32'(want.halted_out), 32'(got.halted_out));
        check_field("pending_level_out", 32'(want.pending_level_out),
                    32'(got.pending_level_out));
        check_field("exception_cycles", 32'(want.exception_cycles),
                    32'(got.exception_cycles));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ext_pending = 8'd0;
            onchip_pending = 8'd0;
            usp_shadow = 32'd0;
            ssp_shadow = 32'd0;
            halted = 1'b0;
            level_select = 8'd0;
            beats_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) level_select = cfg_data;
            if (s_valid && s_ready) predict_entry(s_data);
            if (m_valid && m_ready) begin
                if (beats_due.size() == 0) begin
                    $error("result beat with nothing expected: %0h", m_data);
                    mismatches++;
                end else begin
                    compare_beat(beats_due.pop_front(), m_data);
                end
            end
        end
        fail_count <= mismatches;
        beats_outstanding <= beats_due.size();
    end

endmodule

// ===== tb/sv/m68k_interrupt_exception_entry_unit_tb.sv =====
// Testbench top: drives items and level register writes into the entry unit.
`timescale 1ns / 1ps

module m68k_interrupt_exception_entry_unit_tb;
    import m68kie_pkg::*;

    localparam logic [2:0] ACT_UNUSED      = 3'd7;
    localparam int         PHASES          = 6;
    localparam int         ITEMS_PER_PHASE = 75;
    localparam int         QUIET_PHASE     = 2;
    localparam int         IDLE_PERCENT    = 22;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         TAIL_CYCLES     = 20;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    item_t       s_data;
    logic        m_valid;
    logic        m_ready;
    result_t     m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        quiet;
    int          fail_count;
    int          beats_outstanding;
    int          dead_cycles;
    logic [7:0]  phase_levels [PHASES];

    m68k_interrupt_exception_entry_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    m68kie_frame_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .beats_outstanding (beats_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // end the run when no channel has moved a beat for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
        if (dead_cycles >= WATCHDOG_LIMIT) begin
            $display("m68k_interrupt_exception_entry_unit regression: fail");
            $finish;
        end
    end

    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 14)      it.action = ACT_RAISE_EXT;
        else if (pick < 22) it.action = ACT_RAISE_INPUT;
        else if (pick < 30) it.action = ACT_RAISE_LEVEL;
        else if (pick < 58) it.action = ACT_SAFEPOINT;
        else if (pick < 74) it.action = ACT_EXCEPTION;
        else if (pick < 86) it.action = ACT_WRITE_SR;
        else if (pick < 94) it.action = ACT_STOP;
        else                it.action = ACT_UNUSED;
        it.irq_level = 3'($urandom_range(7));
        it.onchip_input = 2'($urandom_range(3));
        // favor the fault vectors so long frames are common
        it.vector_number = ($urandom_range(99) < 30) ? 8'(2 + $urandom_range(1))
                                                     : 8'($urandom_range(255));
        it.current_sr = 16'($urandom);
        if ($urandom_range(99) < 60) it.current_sr[10:8] = 3'($urandom_range(2));
        it.new_sr_value = 16'($urandom);
        it.stacked_pc = $urandom;
        it.active_stack_pointer = ($urandom_range(99) < 10) ? $urandom_range(40) : $urandom;
        it.fault_address = $urandom;
        it.fault_opcode = 16'($urandom);
        it.delivery_enable = $urandom_range(99) < 85;
        return it;
    endfunction

    function automatic item_t directed(input logic [2:0] act, input logic [2:0] lvl,
                                       input logic [1:0] src, input logic [7:0] vec,
                                       input logic [15:0] sr, input logic en);
        item_t it;
        it = random_item();
        it.action = act;
        it.irq_level = lvl;
        it.onchip_input = src;
        it.vector_number = vec;
        it.current_sr = sr;
        it.delivery_enable = en;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (beats_outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_level_select(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        item_t it;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= 8'd0;
        quiet <= 1'b0;
        phase_levels[0] = 8'hFF;
        phase_levels[1] = 8'h00;
        phase_levels[2] = 8'h7F;
        phase_levels[3] = 8'h35;
        phase_levels[4] = 8'($urandom_range(255));
        phase_levels[5] = 8'($urandom_range(255));
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // input 1 maps to level 5, input 2 to level 3
        write_level_select(8'h53);
        send_item(directed(ACT_RAISE_EXT, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_SAFEPOINT, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_RAISE_LEVEL, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_RAISE_INPUT, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_RAISE_INPUT, 3'd0, 2'd3, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_RAISE_INPUT, 3'd0, 2'd1, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_RAISE_EXT, 3'd5, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_SAFEPOINT, 3'd0, 2'd0, 8'd0, 16'h2000, 1'b1));
        send_item(directed(ACT_SAFEPOINT, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_RAISE_EXT, 3'd3, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_SAFEPOINT, 3'd0, 2'd0, 8'd0, 16'h2300, 1'b1));
        send_item(directed(ACT_SAFEPOINT, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b0));
        send_item(directed(ACT_RAISE_INPUT, 3'd0, 2'd2, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_RAISE_LEVEL, 3'd7, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_STOP, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1));
        // a level 7 request gets through even a full mask
        send_item(directed(ACT_SAFEPOINT, 3'd0, 2'd0, 8'd0, 16'hFFFF, 1'b1));
        send_item(directed(ACT_SAFEPOINT, 3'd0, 2'd0, 8'd0, 16'h2200, 1'b1));
        send_item(directed(ACT_SAFEPOINT, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1));
        it = directed(ACT_EXCEPTION, 3'd0, 2'd0, 8'd2, 16'h0000, 1'b1);
        it.active_stack_pointer = 32'h0000_0006;
        it.stacked_pc = 32'hFFFF_FFFF;
        it.fault_address = 32'hFFFF_FFFF;
        it.fault_opcode = 16'hFFFF;
        send_item(it);
        it = directed(ACT_EXCEPTION, 3'd0, 2'd0, 8'd3, 16'hFFFF, 1'b1);
        it.active_stack_pointer = 32'hFFFF_FFFF;
        it.stacked_pc = 32'h0000_0000;
        it.fault_address = 32'h0000_0000;
        it.fault_opcode = 16'h0000;
        send_item(it);
        send_item(directed(ACT_EXCEPTION, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1));
        send_item(directed(ACT_EXCEPTION, 3'd0, 2'd0, 8'd255, 16'h2000, 1'b1));
        it = directed(ACT_WRITE_SR, 3'd0, 2'd0, 8'd0, 16'h2000, 1'b1);
        it.new_sr_value = 16'h0000;
        send_item(it);
        it = directed(ACT_WRITE_SR, 3'd0, 2'd0, 8'd0, 16'h0000, 1'b1);
        it.new_sr_value = 16'hFFFF;
        send_item(it);
        send_item(directed(ACT_UNUSED, 3'd7, 2'd3, 8'd255, 16'hFFFF, 1'b1));

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            quiet <= (phase == QUIET_PHASE);
            write_level_select(phase_levels[phase]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_item());
        end
        drain_results();
        quiet <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && beats_outstanding == 0)
            $display("m68k_interrupt_exception_entry_unit regression: pass");
        else
            $display("m68k_interrupt_exception_entry_unit regression: fail");
        $finish;
    end

endmodule

// ===== m68k_interrupt_exception_entry_unit.f =====
sv/m68kie_pkg.sv
sv/m68kie_front.sv
sv/m68kie_queue.sv
sv/m68kie_back.sv
sv/m68k_interrupt_exception_entry_unit.sv
tb/sv/m68kie_frame_checker.sv
tb/sv/m68k_interrupt_exception_entry_unit_tb.sv
